// ===== sv/sine_square_waveform_generator_unit_defines.svh =====
// assertion macros for the waveform generator
// no dependencies; included by the top level
`ifndef SINE_SQUARE_WAVEFORM_GENERATOR_UNIT_DEFINES_SVH
`define SINE_SQUARE_WAVEFORM_GENERATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SSWG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SSWG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SSWG_ASSERT(lbl, prop, msg)
`define SSWG_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/sswg_pkg.sv =====
// shared types, register codes and the sine table function
// no dependencies
package sswg_pkg;

    // register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_MODE   = 3'd0,
        REG_AMP    = 3'd1,
        REG_OFFSET = 3'd2,
        REG_PERIOD = 3'd3,
        REG_DUTY   = 3'd4
    } reg_idx_t;

    localparam logic [16:0] DUTY_FULL   = 17'd65536;
    localparam logic [16:0] DUTY_RESET  = 17'd32768;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // per-cell control handed down the chain
    typedef struct packed {
        logic valid;
    } cell_ctl_t;

    // shift and subtract quotient, used only while building the table
    function automatic longint unsigned long_quotient(input longint unsigned a,
                                                      input longint unsigned b);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int i = 63; i >= 0; i--)
        begin
            r = (r << 1) | ((a >> i) & 64'd1);
            q = q << 1;
            if (r >= b)
            begin
                r = r - b;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // quarter-wave sine entry k, evaluated at elaboration
    function automatic longint unsigned quarter_sine(input int k, input int pb, input int sb);
        longint unsigned theta;
        longint unsigned term;
        longint signed   sum;
        longint unsigned smax;
        longint unsigned v;
        longint unsigned dv;
        theta = (longint'(k) * HALF_PI_Q30) >> (pb - 2);
        term  = theta;
        sum   = longint'(theta);
        smax  = (64'd1 << sb) - 64'd1;
        for (int n = 1; n <= 8; n++)
        begin
            term = (((term * theta) >> 30) * theta) >> 30;
            dv   = longint'((2 * n) * (2 * n + 1));
            term = long_quotient(term, dv);
            if ((n & 1) == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        v = ((longint'(sum)) * smax + (64'd1 << 29)) >> 30;
        if (v > smax)
            v = smax;
        return v;
    endfunction

endpackage

// ===== sv/sine_square_waveform_generator_unit.sv =====
// top level of the sine/square waveform generator, depends on sswg_pkg and sswg_div_cell
// registers from input to result: the divide cells, then stages a, b, c and output
// throughput: one item per cycle unless the output stalls; a chain of divide
// cells (32 for the period remainder, PHASE_BITS for the phase) advances every cycle
// unless stalled; the whole chain holds while a result waits on m_tready
// reset: asynchronous active low; config and valid registers reset, payloads do not
module sine_square_waveform_generator_unit import sswg_pkg::*; #(
    parameter int PHASE_BITS  = 12,
    parameter int SINE_BITS   = 16,
    parameter int PERIOD_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] step_index
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [24:0] sample_value, zero filled above
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "sine_square_waveform_generator_unit_defines.svh"

    localparam int PW = PERIOD_BITS;
    localparam int Q  = 1 << (PHASE_BITS - 2);
    localparam int AW = PHASE_BITS - 1;

    // configuration registers
    logic          mode_reg;
    logic [15:0]   amp_reg;
    logic [23:0]   offset_reg;
    logic [PW-1:0] period_reg, period_next;
    logic [16:0]   duty_reg, duty_next;
    logic          wr;
    reg_idx_t      widx;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite & pready;
    assign widx   = reg_idx_t'(paddr[4:2]);

    always_comb
    begin
        period_next = (pwdata[PW-1:0] == '0) ? PW'(1) : pwdata[PW-1:0];
        duty_next   = (pwdata[16:0] > DUTY_FULL) ? DUTY_FULL : pwdata[16:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            amp_reg    <= '0;
            offset_reg <= '0;
            period_reg <= PW'(1);
            duty_reg   <= DUTY_RESET;
        end
        else if (wr)
        begin
            unique case (widx)
                REG_MODE:   mode_reg   <= pwdata[0];
                REG_AMP:    amp_reg    <= pwdata[15:0];
                REG_OFFSET: offset_reg <= pwdata[23:0];
                REG_PERIOD: period_reg <= period_next;
                REG_DUTY:   duty_reg   <= duty_next;
                default:    ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (widx)
            REG_MODE:   prdata = {31'd0, mode_reg};
            REG_AMP:    prdata = {16'd0, amp_reg};
            REG_OFFSET: prdata = {8'd0, offset_reg};
            REG_PERIOD: prdata = 32'(period_reg);
            REG_DUTY:   prdata = {15'd0, duty_reg};
            default:    prdata = '0;
        endcase
    end

    // chain advances unless a result is stuck at the output
    logic en;
    assign en       = !(m_tvalid && !m_tready);
    assign s_tready = en;

    // remainder chain: step_index mod period
    cell_ctl_t     mctl [33];
    logic [PW-1:0] mrem [33];
    logic [31:0]   mdat [33];
    logic          mtag [33];

    assign mctl[0].valid = s_tvalid;
    assign mrem[0]       = '0;
    assign mdat[0]       = s_tdata;
    assign mtag[0]       = 1'b0;

    for (genvar i = 0; i < 32; i++)
    begin : g_mod
        sswg_div_cell #(.RW(PW), .DW(32), .TW(1)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .ctl_in(mctl[i]), .rem_in(mrem[i]), .data_in(mdat[i]), .tag_in(mtag[i]),
            .divisor(period_reg),
            .ctl_out(mctl[i+1]), .rem_out(mrem[i+1]), .data_out(mdat[i+1]),
            .tag_out(mtag[i+1])
        );
    end

    // phase chain: (m << PHASE_BITS) / period, m rides along as tag
    cell_ctl_t             pctl [PHASE_BITS+1];
    logic [PW-1:0]         prem [PHASE_BITS+1];
    logic [PHASE_BITS-1:0] pdat [PHASE_BITS+1];
    logic [PW-1:0]         ptag [PHASE_BITS+1];

    assign pctl[0] = mctl[32];
    assign prem[0] = mrem[32];
    assign pdat[0] = '0;
    assign ptag[0] = mrem[32];

    for (genvar i = 0; i < PHASE_BITS; i++)
    begin : g_phase
        sswg_div_cell #(.RW(PW), .DW(PHASE_BITS), .TW(PW)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .ctl_in(pctl[i]), .rem_in(prem[i]), .data_in(pdat[i]), .tag_in(ptag[i]),
            .divisor(period_reg),
            .ctl_out(pctl[i+1]), .rem_out(prem[i+1]), .data_out(pdat[i+1]),
            .tag_out(ptag[i+1])
        );
    end

    // quarter-wave table
    logic [SINE_BITS-1:0] sine_rom [Q+1];
    for (genvar k = 0; k <= Q; k++)
    begin : g_rom
        localparam longint unsigned SV = quarter_sine(k, PHASE_BITS, SINE_BITS);
        assign sine_rom[k] = SINE_BITS'(SV);
    end

    // stage a: table address and sign
    logic                  a_valid_reg;
    logic [AW-1:0]         a_addr_reg, a_addr_next;
    logic                  a_neg_reg;
    logic [PW-1:0]         a_m_reg;
    logic [PHASE_BITS-1:0] phase;

    assign phase = pdat[PHASE_BITS];

    always_comb
    begin
        if (phase[PHASE_BITS-2])
            a_addr_next = AW'(Q) - {1'b0, phase[PHASE_BITS-3:0]};
        else
            a_addr_next = {1'b0, phase[PHASE_BITS-3:0]};
    end

    // stage b: table read and duty compare
    logic                 b_valid_reg;
    logic [SINE_BITS-1:0] b_sine_reg;
    logic                 b_neg_reg;
    logic                 b_high_reg;
    logic [PW+16:0]       duty_prod;
    logic [PW+16:0]       m_scaled;

    assign duty_prod = (PW+17)'(duty_reg) * (PW+17)'(period_reg);
    assign m_scaled  = (PW+17)'({a_m_reg, 16'd0});

    // stage c: amplitude product
    logic                    c_valid_reg;
    logic [SINE_BITS+15:0]   c_prod_reg;
    logic                    c_neg_reg;
    logic                    c_high_reg;

    // output stage
    logic                    o_valid_reg;
    logic [24:0]             o_value_reg, o_value_next;
    logic [SINE_BITS+16:0]   rounded;
    logic [16:0]             mag;
    logic [24:0]             off_ext;

    always_comb
    begin
        rounded = (SINE_BITS+17)'(c_prod_reg) + ((SINE_BITS+17)'(1) << (SINE_BITS - 1));
        mag     = 17'(rounded >> SINE_BITS);
        off_ext = {offset_reg[23], offset_reg};
        if (mode_reg)
            o_value_next = c_high_reg ? off_ext + 25'(amp_reg) : off_ext;
        else if (c_neg_reg)
            o_value_next = off_ext - 25'(mag);
        else
            o_value_next = off_ext + 25'(mag);
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= pctl[PHASE_BITS].valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            o_valid_reg <= c_valid_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_addr_reg  <= a_addr_next;
            a_neg_reg   <= phase[PHASE_BITS-1];
            a_m_reg     <= ptag[PHASE_BITS];
            b_sine_reg  <= sine_rom[a_addr_reg];
            b_neg_reg   <= a_neg_reg;
            b_high_reg  <= m_scaled < duty_prod;
            c_prod_reg  <= (SINE_BITS+16)'(amp_reg) * (SINE_BITS+16)'(b_sine_reg);
            c_neg_reg   <= b_neg_reg;
            c_high_reg  <= b_high_reg;
            o_value_reg <= o_value_next;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {7'd0, o_value_reg};

    // checks
    `SSWG_ASSERT(a_period_nonzero, period_reg != '0, "period register holds zero")
    `SSWG_ASSERT(a_duty_range, duty_reg <= DUTY_FULL, "duty register above full scale")
    `SSWG_ASSERT(a_stall_blocks_input, !(m_tvalid && !m_tready) || !s_tready, "input taken during output stall")
    `SSWG_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, $stable(o_value_reg), "stalled result changed")

endmodule

// ===== sv/sswg_div_cell.sv =====
// one restoring divide step: shift in a dividend bit, conditional subtract
// depends on sswg_pkg
module sswg_div_cell import sswg_pkg::*; #(
    parameter int RW = 24,
    parameter int DW = 32,
    parameter int TW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  cell_ctl_t     ctl_in,
    input  logic [RW-1:0] rem_in,
    input  logic [DW-1:0] data_in,
    input  logic [TW-1:0] tag_in,
    input  logic [RW-1:0] divisor,
    output cell_ctl_t     ctl_out,
    output logic [RW-1:0] rem_out,
    output logic [DW-1:0] data_out,
    output logic [TW-1:0] tag_out
);

    cell_ctl_t     ctl_reg;
    logic [RW-1:0] rem_reg, rem_next;
    logic [DW-1:0] data_reg, data_next;
    logic [TW-1:0] tag_reg;
    logic [RW:0]   trial;
    logic          ge;

    // trial subtract of the divisor from the shifted remainder
    always_comb
    begin
        trial     = {rem_in, data_in[DW-1]};
        ge        = trial >= {1'b0, divisor};
        rem_next  = ge ? RW'(trial - {1'b0, divisor}) : trial[RW-1:0];
        data_next = {data_in[DW-2:0], ge};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= ctl_in;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            data_reg <= data_next;
            tag_reg  <= tag_in;
        end
    end

    assign ctl_out  = ctl_reg;
    assign rem_out  = rem_reg;
    assign data_out = data_reg;
    assign tag_out  = tag_reg;

endmodule
